[rtl/vrot_pkg.sv]
// Shared constants, axis codes and the CORDIC arctangent table for the vector rotator.
`default_nettype none
package vrot_pkg;

  localparam int COORD_BITS_DEF   = 32;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // CORDIC datapath width: Q2.30 plus headroom
  localparam int CW = 33;

  // 1/K of an endless CORDIC, Q2.30
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [CW-1:0] Q30_ONE         = 33'sd1073741824;

  // axis select codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // fraction bits of the rounded sine / cosine
  function automatic int trig_frac(input int cb);
    return ((61 - cb) < 30) ? (61 - cb) : 30;
  endfunction

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/vec3_axis_rotation.sv]
// Top level of the 3D vector rotator about a coordinate axis.
`default_nettype none
// Rotates a signed Q16.16 vector (COORD_BITS wide) about the x, y or z axis by
// an angle in binary units (2^ANGLE_BITS per turn). Cosine and sine come from
// a gain-compensated CORDIC with one pipeline stage per micro-rotation, then a
// quadrant fold and rounding stage, a multiply stage (four products), a sum
// stage and a round/saturate stage that is the output register. Axis code 3
// passes the vector through untouched. Throughput is one request per clock
// while out_ready does not hold it. The whole pipeline advances together:
// when out_valid is high and out_ready is low every stage holds, and
// in_ready drops in the same cycle, so no request is lost or duplicated.
// in_ready therefore follows out_ready combinationally.
module vec3_axis_rotation
  import vrot_pkg::*;
#(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_mode,
  input  wire logic [COORD_BITS-1:0]  in_x_in,
  input  wire logic [COORD_BITS-1:0]  in_y_in,
  input  wire logic [COORD_BITS-1:0]  in_z_in,
  input  wire logic [ANGLE_BITS-1:0]  in_turn_angle,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [COORD_BITS-1:0]       out_x_out,
  output logic [COORD_BITS-1:0]       out_y_out,
  output logic [COORD_BITS-1:0]       out_z_out
);

  localparam int TF  = trig_frac(COORD_BITS);
  localparam int PLW = 2 + 3*COORD_BITS;
  localparam int ZSH = 32 - ANGLE_BITS;

  // global stage enable
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // CORDIC chain: index 0 is the request as it arrives
  logic                 c_vld  [0:CORDIC_STEPS];
  logic signed [CW-1:0] c_x    [0:CORDIC_STEPS];
  logic signed [CW-1:0] c_y    [0:CORDIC_STEPS];
  logic signed [CW-1:0] c_z    [0:CORDIC_STEPS];
  logic [1:0]           c_quad [0:CORDIC_STEPS];
  logic [PLW-1:0]       c_pl   [0:CORDIC_STEPS];

  assign c_vld[0]  = in_valid;
  assign c_x[0]    = CORDIC_GAIN_Q30;
  assign c_y[0]    = '0;
  // residual angle within the quadrant, scaled to 2^32 per turn
  assign c_z[0]    = CW'(in_turn_angle[ANGLE_BITS-3:0]) << ZSH;
  assign c_quad[0] = in_turn_angle[ANGLE_BITS-1 -: 2];
  assign c_pl[0]   = {in_mode, in_x_in, in_y_in, in_z_in};

  generate
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      vrot_cstep #(
        .IDX (i),
        .PLW (PLW)
      ) u_cstep (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (c_vld[i]),
        .in_cx    (c_x[i]),
        .in_cy    (c_y[i]),
        .in_cz    (c_z[i]),
        .in_quad  (c_quad[i]),
        .in_pl    (c_pl[i]),
        .out_vld  (c_vld[i+1]),
        .out_cx   (c_x[i+1]),
        .out_cy   (c_y[i+1]),
        .out_cz   (c_z[i+1]),
        .out_quad (c_quad[i+1]),
        .out_pl   (c_pl[i+1])
      );
    end
  endgenerate

  // quadrant fold, clamp, round to TF fraction bits
  logic                 t_vld;
  logic signed [TF+1:0] t_cos, t_sin;
  logic [PLW-1:0]       t_pl;

  vrot_trig #(
    .TF  (TF),
    .PLW (PLW)
  ) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (c_vld[CORDIC_STEPS]),
    .in_cx   (c_x[CORDIC_STEPS]),
    .in_cy   (c_y[CORDIC_STEPS]),
    .in_quad (c_quad[CORDIC_STEPS]),
    .in_pl   (c_pl[CORDIC_STEPS]),
    .out_vld (t_vld),
    .out_cos (t_cos),
    .out_sin (t_sin),
    .out_pl  (t_pl)
  );

  // products, sums, round and saturate; last stage is the output register
  vrot_mac #(
    .CB (COORD_BITS),
    .TF (TF)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (t_vld),
    .in_cos  (t_cos),
    .in_sin  (t_sin),
    .in_pl   (t_pl),
    .out_vld (out_valid),
    .out_x   (out_x_out),
    .out_y   (out_y_out),
    .out_z   (out_z_out)
  );

endmodule
`default_nettype wire

[rtl/vrot_cstep.sv]
// One CORDIC micro-rotation stage with its pipeline register.
`default_nettype none
module vrot_cstep
  import vrot_pkg::*;
#(
  parameter int IDX = 0,
  parameter int PLW = 98
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_vld,
  input  wire logic signed [CW-1:0]  in_cx,
  input  wire logic signed [CW-1:0]  in_cy,
  input  wire logic signed [CW-1:0]  in_cz,
  input  wire logic [1:0]            in_quad,
  input  wire logic [PLW-1:0]        in_pl,
  output logic                       out_vld,
  output logic signed [CW-1:0]       out_cx,
  output logic signed [CW-1:0]       out_cy,
  output logic signed [CW-1:0]       out_cz,
  output logic [1:0]                 out_quad,
  output logic [PLW-1:0]             out_pl
);

  localparam logic signed [CW-1:0] ATAN = $signed({1'b0, atan_turn(IDX)});

  logic                     vld_r;
  logic signed [CW-1:0]     cx_r, cy_r, cz_r;
  logic signed [CW-1:0]     cx_nxt, cy_nxt, cz_nxt;
  logic signed [CW-1:0]     dx, dy;
  logic [1:0]               quad_r;
  logic [PLW-1:0]           pl_r;

  assign dx = in_cy >>> IDX;
  assign dy = in_cx >>> IDX;

  always_comb begin
    if (!in_cz[CW-1]) begin
      cx_nxt = in_cx - dx;
      cy_nxt = in_cy + dy;
      cz_nxt = in_cz - ATAN;
    end else begin
      cx_nxt = in_cx + dx;
      cy_nxt = in_cy - dy;
      cz_nxt = in_cz + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cz_r   <= cz_nxt;
      quad_r <= in_quad;
      pl_r   <= in_pl;
    end
  end

  assign out_vld  = vld_r;
  assign out_cx   = cx_r;
  assign out_cy   = cy_r;
  assign out_cz   = cz_r;
  assign out_quad = quad_r;
  assign out_pl   = pl_r;

endmodule
`default_nettype wire

[rtl/vrot_trig.sv]
// Quadrant fold, clamp and rounding of the CORDIC cosine / sine.
`default_nettype none
module vrot_trig
  import vrot_pkg::*;
#(
  parameter int TF  = 29,
  parameter int PLW = 98
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_vld,
  input  wire logic signed [CW-1:0]  in_cx,
  input  wire logic signed [CW-1:0]  in_cy,
  input  wire logic [1:0]            in_quad,
  input  wire logic [PLW-1:0]        in_pl,
  output logic                       out_vld,
  output logic signed [TF+1:0]       out_cos,
  output logic signed [TF+1:0]       out_sin,
  output logic [PLW-1:0]             out_pl
);

  localparam int SH = 30 - TF;

  logic signed [CW-1:0] c_map, s_map, c_clp, s_clp;
  logic signed [TF+1:0] c_nxt, s_nxt, c_r, s_r;
  logic                 vld_r;
  logic [PLW-1:0]       pl_r;

  always_comb begin
    case (in_quad)
      2'd0: begin
        c_map = in_cx;
        s_map = in_cy;
      end
      2'd1: begin
        c_map = -in_cy;
        s_map = in_cx;
      end
      2'd2: begin
        c_map = -in_cx;
        s_map = -in_cy;
      end
      default: begin
        c_map = in_cy;
        s_map = -in_cx;
      end
    endcase
  end

  assign c_clp = (c_map > Q30_ONE) ? Q30_ONE : ((c_map < -Q30_ONE) ? -Q30_ONE : c_map);
  assign s_clp = (s_map > Q30_ONE) ? Q30_ONE : ((s_map < -Q30_ONE) ? -Q30_ONE : s_map);

  generate
    if (SH == 0) begin : g_norund
      assign c_nxt = c_clp[TF+1:0];
      assign s_nxt = s_clp[TF+1:0];
    end else begin : g_rund
      localparam logic signed [CW-1:0] HALF = CW'(1) << (SH - 1);
      logic signed [CW-1:0] c_sh, s_sh;
      assign c_sh  = (c_clp + HALF) >>> SH;
      assign s_sh  = (s_clp + HALF) >>> SH;
      assign c_nxt = c_sh[TF+1:0];
      assign s_nxt = s_sh[TF+1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r  <= c_nxt;
      s_r  <= s_nxt;
      pl_r <= in_pl;
    end
  end

  assign out_vld = vld_r;
  assign out_cos = c_r;
  assign out_sin = s_r;
  assign out_pl  = pl_r;

endmodule
`default_nettype wire

[rtl/vrot_mac.sv]
// Coordinate multiply, sum, round and saturate: three pipeline stages.
`default_nettype none
module vrot_mac
  import vrot_pkg::*;
#(
  parameter int CB = 32,
  parameter int TF = 29
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_vld,
  input  wire logic signed [TF+1:0]  in_cos,
  input  wire logic signed [TF+1:0]  in_sin,
  input  wire logic [2+3*CB-1:0]     in_pl,
  output logic                       out_vld,
  output logic [CB-1:0]              out_x,
  output logic [CB-1:0]              out_y,
  output logic [CB-1:0]              out_z
);

  localparam int PLW = 2 + 3*CB;
  localparam int PW  = CB + TF + 2;   // product width
  localparam int AW  = PW + 1;        // sum width
  localparam int RW  = AW + 1;        // rounding width

  localparam logic signed [RW-1:0] HALF   = {{(RW-TF){1'b0}}, 1'b1, {(TF-1){1'b0}}};
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-CB+1){1'b1}}, {(CB-1){1'b0}}};

  // multiply stage
  logic [1:0]           mode;
  logic signed [CB-1:0] ax, ay, az, op_a, op_b;
  logic signed [PW-1:0] p_ac_r, p_bs_r, p_as_r, p_bc_r;
  logic                 m_vld_r;
  logic [PLW-1:0]       m_pl_r;

  assign mode = in_pl[PLW-1 -: 2];
  assign ax   = $signed(in_pl[3*CB-1 -: CB]);
  assign ay   = $signed(in_pl[2*CB-1 -: CB]);
  assign az   = $signed(in_pl[CB-1:0]);

  // the two rotated coordinates, in (cos, -sin) order
  always_comb begin
    case (mode)
      AXIS_X: begin
        op_a = ay;
        op_b = az;
      end
      AXIS_Y: begin
        op_a = ax;
        op_b = az;
      end
      default: begin
        op_a = ax;
        op_b = ay;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ac_r <= PW'(op_a) * PW'(in_cos);
      p_bs_r <= PW'(op_b) * PW'(in_sin);
      p_as_r <= PW'(op_a) * PW'(in_sin);
      p_bc_r <= PW'(op_b) * PW'(in_cos);
      m_pl_r <= in_pl;
    end
  end

  // sum stage
  logic signed [AW-1:0] acc0_r, acc1_r;
  logic                 s_vld_r;
  logic [PLW-1:0]       s_pl_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc0_r <= AW'(p_ac_r) - AW'(p_bs_r);
      acc1_r <= AW'(p_as_r) + AW'(p_bc_r);
      s_pl_r <= m_pl_r;
    end
  end

  // round half up to 16 fraction bits and saturate
  logic signed [RW-1:0] r0, r1;
  logic [CB-1:0]        q0, q1;
  logic [1:0]           s_mode;
  logic [CB-1:0]        s_x, s_y, s_z;
  logic [CB-1:0]        x_nxt, y_nxt, z_nxt, x_r, y_r, z_r;
  logic                 f_vld_r;

  assign r0 = (RW'(acc0_r) + HALF) >>> TF;
  assign r1 = (RW'(acc1_r) + HALF) >>> TF;
  assign q0 = (r0 > SAT_HI) ? SAT_HI[CB-1:0] : ((r0 < SAT_LO) ? SAT_LO[CB-1:0] : r0[CB-1:0]);
  assign q1 = (r1 > SAT_HI) ? SAT_HI[CB-1:0] : ((r1 < SAT_LO) ? SAT_LO[CB-1:0] : r1[CB-1:0]);

  assign s_mode = s_pl_r[PLW-1 -: 2];
  assign s_x    = s_pl_r[3*CB-1 -: CB];
  assign s_y    = s_pl_r[2*CB-1 -: CB];
  assign s_z    = s_pl_r[CB-1:0];

  always_comb begin
    x_nxt = s_x;
    y_nxt = s_y;
    z_nxt = s_z;
    case (s_mode)
      AXIS_X: begin
        y_nxt = q0;
        z_nxt = q1;
      end
      AXIS_Y: begin
        x_nxt = q0;
        z_nxt = q1;
      end
      AXIS_Z: begin
        x_nxt = q0;
        y_nxt = q1;
      end
      default: begin
        // no rotation: all coordinates pass
        x_nxt = s_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= in_vld;
      s_vld_r <= m_vld_r;
      f_vld_r <= s_vld_r;
    end
  end

  assign out_vld = f_vld_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;

endmodule
`default_nettype wire

[sim/vec3_axis_rotation_test.sv]
// Self-checking testbench for the vec3_axis_rotation CORDIC axis rotator.
module vec3_axis_rotation_test
  import vrot_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // widths follow the block's defaults
  localparam int CB    = COORD_BITS_DEF;
  localparam int AB    = ANGLE_BITS_DEF;
  localparam int STEPS = (CORDIC_STEPS_DEF > 32) ? 32 : CORDIC_STEPS_DEF;
  // sine/cosine fraction bits after rounding
  localparam int TF    = ((61 - CB) < 30) ? (61 - CB) : 30;

  // pipeline depth: one stage per micro-rotation plus four
  localparam int LATENCY    = CORDIC_STEPS_DEF + 4;
  // cycles without any handshake before the run is declared hung
  localparam int IDLE_LIMIT = 2000;

  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint UNIT_Q30 = 64'sd1073741824;

  typedef struct {
    logic [1:0]    mode;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    logic [AB-1:0] angle;
  } rot_request_t;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
  } rot_vector_t;

  // atan(2^-i), 2^32 units per turn
  longint atan_steps [0:31] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
    'h00000001, 'h00000000};

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    in_mode;
  logic [CB-1:0] in_x_in;
  logic [CB-1:0] in_y_in;
  logic [CB-1:0] in_z_in;
  logic [AB-1:0] in_turn_angle;
  logic          out_valid;
  logic          out_ready;
  logic [CB-1:0] out_x_out;
  logic [CB-1:0] out_y_out;
  logic [CB-1:0] out_z_out;

  rot_vector_t expected_vectors[$];
  int          error_count  = 0;
  int          result_count = 0;
  int          idle_cycles  = 0;
  int          burst_left   = 0;

  vec3_axis_rotation #(
    .COORD_BITS  (CB),
    .ANGLE_BITS  (AB),
    .CORDIC_STEPS(CORDIC_STEPS_DEF)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_x_in      (in_x_in),
    .in_y_in      (in_y_in),
    .in_z_in      (in_z_in),
    .in_turn_angle(in_turn_angle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x_out    (out_x_out),
    .out_y_out    (out_y_out),
    .out_z_out    (out_z_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // round half up by s bits (floor shift after adding half an lsb)
  function automatic longint round_half_up(input longint v, input int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_range(input longint v, input longint lo,
                                         input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // scale a Q.(16+TF) sum back to Q.16 and saturate to the coordinate range
  function automatic logic [CB-1:0] saturate_coord(input longint acc);
    longint hi;
    longint v;
    hi = (64'sd1 <<< (CB - 1)) - 1;
    v  = clamp_range(round_half_up(acc, TF), -hi - 1, hi);
    return v[CB-1:0];
  endfunction

  function automatic rot_vector_t predict_rotation(input rot_request_t r);
    longint      cx, cy, resid, dx, dy, t, cosv, sinv, a, b;
    logic [1:0]  quad;
    rot_vector_t res;
    res.x = r.x;
    res.y = r.y;
    res.z = r.z;
    if (r.mode == AXIS_NONE) return res;

    // quadrant from the top two angle bits, the rest scaled to 2^32 per turn
    quad  = r.angle[AB-1 -: 2];
    resid = longint'(r.angle[AB-3:0]) << (32 - AB);
    cx = GAIN_Q30;
    cy = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (resid >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        resid = resid - atan_steps[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        resid = resid + atan_steps[i];
      end
    end
    cosv = cx;
    sinv = cy;
    case (quad)
      2'd1: begin
        t = cosv; cosv = -sinv; sinv = t;
      end
      2'd2: begin
        cosv = -cosv; sinv = -sinv;
      end
      2'd3: begin
        t = cosv; cosv = sinv; sinv = -t;
      end
      default: ;
    endcase
    cosv = round_half_up(clamp_range(cosv, -UNIT_Q30, UNIT_Q30), 30 - TF);
    sinv = round_half_up(clamp_range(sinv, -UNIT_Q30, UNIT_Q30), 30 - TF);

    // a and b are the two rotated coordinates; the axis one passes through
    case (r.mode)
      AXIS_X: begin
        a = longint'(signed'(r.y));
        b = longint'(signed'(r.z));
        res.y = saturate_coord(a * cosv - b * sinv);
        res.z = saturate_coord(a * sinv + b * cosv);
      end
      AXIS_Y: begin
        a = longint'(signed'(r.x));
        b = longint'(signed'(r.z));
        res.x = saturate_coord(a * cosv - b * sinv);
        res.z = saturate_coord(a * sinv + b * cosv);
      end
      default: begin
        a = longint'(signed'(r.x));
        b = longint'(signed'(r.y));
        res.x = saturate_coord(a * cosv - b * sinv);
        res.y = saturate_coord(a * sinv + b * cosv);
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Request side: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------

  task automatic send_request(input rot_request_t r);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      if (burst_left == 0 && $urandom_range(0, 3) == 0)
        burst_left = $urandom_range(64, 200);  // long stretch with no gaps
      else
        burst_left = $urandom_range(1, 12);
      if (in_valid == 1'b0) @(negedge clk);
    end
    burst_left--;
    in_valid      = 1'b1;
    in_mode       = r.mode;
    in_x_in       = r.x;
    in_y_in       = r.y;
    in_z_in       = r.z;
    in_turn_angle = r.angle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_vectors.push_back(predict_rotation(r));
  endtask

  task automatic send_vec(input logic [1:0] m, input logic [CB-1:0] x,
                          input logic [CB-1:0] y, input logic [CB-1:0] z,
                          input logic [AB-1:0] ang);
    rot_request_t r;
    r.mode  = m;
    r.x     = x;
    r.y     = y;
    r.z     = z;
    r.angle = ang;
    send_request(r);
  endtask

  function automatic logic [CB-1:0] rand_coord();
    logic signed [19:0] small_val;
    small_val = 20'($urandom());
    case ($urandom_range(0, 7))
      0: return {1'b0, {(CB-1){1'b1}}} - $urandom_range(0, 3);
      1: return {1'b1, {(CB-1){1'b0}}} + $urandom_range(0, 3);
      2: return CB'($urandom_range(0, 2)) - 1;
      3, 4: return {{(CB-20){small_val[19]}}, small_val};
      default: return CB'($urandom());
    endcase
  endfunction

  function automatic logic [AB-1:0] rand_angle();
    logic [AB-1:0] base;
    case ($urandom_range(0, 3))
      // close to a quadrant boundary
      0: begin
        base = AB'($urandom_range(0, 3)) << (AB - 2);
        return base + AB'($urandom_range(0, 4)) - AB'(2);
      end
      default: return AB'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result side: stall pattern of its own, changed phase by phase
  // ---------------------------------------------------------------------

  initial begin
    int kind;
    int len;
    int period;
    int duty;
    out_ready = 1'b0;
    forever begin
      kind   = $urandom_range(0, 4);
      len    = $urandom_range(16, 160);
      period = $urandom_range(2, 9);
      duty   = $urandom_range(1, period - 1);
      for (int n = 0; n < len; n++) begin
        @(negedge clk);
        case (kind)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 7) != 0);
          3: out_ready = ((n % period) < duty);
          default: out_ready = (n >= 30);  // one long stall at phase start
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic check_field(input string name, input logic [CB-1:0] exp_val,
                             input logic [CB-1:0] act_val);
    if (act_val !== exp_val) begin
      error_count++;
      $display("%0t: result %0d %s mismatch, expected %h actual %h",
               $realtime, result_count, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    rot_vector_t exp_vec;
    if (rst_n && out_valid && out_ready) begin
      if (expected_vectors.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none actual %h %h %h",
                 $realtime, out_x_out, out_y_out, out_z_out);
      end else begin
        exp_vec = expected_vectors.pop_front();
        check_field("x_out", exp_vec.x, out_x_out);
        check_field("y_out", exp_vec.y, out_y_out);
        check_field("z_out", exp_vec.z, out_z_out);
      end
      result_count++;
    end
  end

  // watchdog: too long without any handshake means the block is stuck
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $realtime, IDLE_LIMIT, expected_vectors.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // axis extremes, right angles, saturation, the y-axis sign convention
  // and the pass-through code
  task automatic test_directed_cases();
    logic [CB-1:0] cmax;
    logic [CB-1:0] cmin;
    logic [CB-1:0] one;
    cmax = {1'b0, {(CB-1){1'b1}}};
    cmin = {1'b1, {(CB-1){1'b0}}};
    one  = CB'(32'h0001_0000);
    send_vec(AXIS_Z, one, '0, CB'(32'h1234_5678), AB'(0));
    send_vec(AXIS_Z, one, '0, '0, AB'(16384));
    send_vec(AXIS_Z, one, '0, '0, AB'(32768));
    send_vec(AXIS_Z, one, one << 1, '0, AB'(49152));
    // 45 degrees on full-scale inputs: the y sum overflows and saturates
    send_vec(AXIS_Z, cmax, cmax, '0, AB'(8192));
    send_vec(AXIS_Z, cmin, cmin, '0, AB'(8192));
    send_vec(AXIS_Z, cmin, cmax, cmin, '1);
    send_vec(AXIS_X, '1, cmax, cmin, AB'(24576));
    send_vec(AXIS_X, '0, one, one, AB'(16383));
    send_vec(AXIS_X, cmax, cmin, cmax, AB'(0));
    send_vec(AXIS_X, '0, cmax, cmax, AB'(57344));
    send_vec(AXIS_X, CB'(32'h5555_5555), CB'(32'hAAAA_AAAA),
             CB'(32'h5555_5555), AB'(16'hAAAA));
    // y axis uses x*c - z*s for x, opposite to the right-hand convention
    send_vec(AXIS_Y, one, CB'(32'hDEAD_BEEF), '0, AB'(16384));
    send_vec(AXIS_Y, cmin, '0, cmax, AB'(40960));
    send_vec(AXIS_Y, '1, CB'(5), '1, AB'(1));
    send_vec(AXIS_Y, CB'(1), '1, CB'(1), AB'(49151));
    send_vec(AXIS_Z, CB'(32'hAAAA_AAAA), CB'(32'h5555_5555), '0, AB'(16'h5555));
    // axis code three: vector untouched
    send_vec(AXIS_NONE, cmax, cmin, CB'(32'hA5A5_A5A5), AB'(12345));
    send_vec(AXIS_NONE, '0, '1, cmin, '1);
  endtask

  task automatic test_random_rotations(input int count);
    rot_request_t r;
    for (int n = 0; n < count; n++) begin
      r.mode  = ($urandom_range(0, 7) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
      r.x     = rand_coord();
      r.y     = rand_coord();
      r.z     = rand_coord();
      r.angle = rand_angle();
      send_request(r);
    end
  endtask

  // hold off until the pipeline has emptied, then refill it back to back
  task automatic test_drain_and_resume();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_vectors.size() != 0) @(posedge clk);
    burst_left = 40;
    test_random_rotations(40);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = AXIS_X;
    in_x_in       = '0;
    in_y_in       = '0;
    in_z_in       = '0;
    in_turn_angle = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_random_rotations(1000);
    test_drain_and_resume();
    test_random_rotations(960);

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_vectors.size() != 0) @(posedge clk);
    // any result arriving now is one too many
    repeat (2 * LATENCY) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vrot_pkg.sv
rtl/vrot_cstep.sv
rtl/vrot_trig.sv
rtl/vrot_mac.sv
rtl/vec3_axis_rotation.sv
sim/vec3_axis_rotation_test.sv
